@@ src/windowed_metric_stats_defines.svh @@
// assertion macros shared by the statistics block
`ifndef WINDOWED_METRIC_STATS_DEFINES_SVH
`define WINDOWED_METRIC_STATS_DEFINES_SVH

// condition implies consequence in the same cycle
`define WMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define WMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wms_pkg.sv @@
// types and constants of the windowed metric statistics block
package wms_pkg;

  localparam int DATA_W       = 32;
  localparam int BUSY_W       = 24;
  localparam int COUNT_W      = 8;
  localparam int METRIC_IDX_W = 3;
  localparam int CFG_IDX_W    = 2;

  // action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd2;

  // register reset values
  localparam logic               ENABLE_RESET    = 1'b0;
  localparam logic [DATA_W-1:0]  THRESHOLD_RESET = 32'd11718750;
  localparam logic [COUNT_W-1:0] WARMUP_RESET    = 8'd30;

  // metric slots
  localparam int MET_TASK = 0;
  localparam int MET_CMD  = 1;
  localparam int MET_PIPE = 2;
  localparam int MET_TMEM = 3;
  localparam int MET_AUX  = 4;

  typedef struct packed {
    logic              action;
    logic              eligible;
    logic              aa_fault;
    logic [DATA_W-1:0] task_ticks;
    logic [BUSY_W-1:0] cmd_busy;
    logic [BUSY_W-1:0] pipe_busy;
    logic [BUSY_W-1:0] tmem_busy;
    logic [DATA_W-1:0] aux_ticks;
  } in_item_t;

  typedef struct packed {
    logic               have_window;
    logic [COUNT_W-1:0] collected;
    logic [COUNT_W-1:0] warmup_left;
    logic [DATA_W-1:0]  rejected;
    logic               aa_error;
  } stat_t;

  typedef struct packed {
    logic                    done;
    logic [METRIC_IDX_W-1:0] idx;
    logic                    last;
    stat_t                   stat;
    logic [DATA_W-1:0]       sum;
    logic [DATA_W-1:0]       mx;
  } issue_t;

endpackage

@@ src/wms_stats.sv @@
// statistics state, per-item update and result sequencing
`include "windowed_metric_stats_defines.svh"

module wms_stats #(
  parameter int WINDOW  = 60,
  parameter int METRICS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  inq_valid,
  input  wms_pkg::in_item_t     inq_item,
  input  logic                  cfg_enable,
  input  logic [31:0]           cfg_threshold,
  input  logic [7:0]            cfg_warmup,
  input  logic                  adv,
  output logic                  take,
  output logic                  issue_valid,
  output wms_pkg::issue_t       issue
);
  import wms_pkg::*;

  localparam int IDX_W = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(METRICS - 1);
  localparam logic [COUNT_W-1:0] WIN_C = COUNT_W'(WINDOW);

  // statistics state
  logic [DATA_W-1:0]  sums_r [METRICS];
  logic [DATA_W-1:0]  max_r  [METRICS];
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] warm_r;
  logic [DATA_W-1:0]  rej_r;
  logic               aa_r;
  logic               pub_r;

  logic [DATA_W-1:0]  sums_nxt [METRICS];
  logic [DATA_W-1:0]  max_nxt  [METRICS];
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] warm_nxt;
  logic [DATA_W-1:0]  rej_nxt;
  logic               aa_nxt;
  logic               pub_nxt;
  logic               done_nxt;

  logic [DATA_W-1:0]  vals    [METRICS];
  logic [DATA_W-1:0]  acc_sum [METRICS];
  logic [DATA_W-1:0]  acc_max [METRICS];
  logic [COUNT_W-1:0] count_inc;

  // pending results of one item
  logic               job_valid_r;
  logic               job_done_r;
  stat_t              job_stat_r;
  logic [IDX_W-1:0]   iss_idx_r;
  logic [DATA_W-1:0]  snap_sum_r [METRICS];
  logic [DATA_W-1:0]  snap_max_r [METRICS];
  logic               iss_last;
  logic               job_free;

  always_comb begin
    for (int i = 0; i < METRICS; i++) begin
      vals[i] = '0;
      if (i == MET_TASK) vals[i] = inq_item.task_ticks;
      if (i == MET_CMD)  vals[i] = DATA_W'(inq_item.cmd_busy);
      if (i == MET_PIPE) vals[i] = DATA_W'(inq_item.pipe_busy);
      if (i == MET_TMEM) vals[i] = DATA_W'(inq_item.tmem_busy);
      if (i == MET_AUX)  vals[i] = inq_item.aux_ticks;
      acc_sum[i] = sums_r[i] + vals[i];
      acc_max[i] = (vals[i] > max_r[i]) ? vals[i] : max_r[i];
    end
    count_inc = count_r + 8'd1;
  end

  always_comb begin
    sums_nxt  = sums_r;
    max_nxt   = max_r;
    count_nxt = count_r;
    warm_nxt  = warm_r;
    rej_nxt   = rej_r;
    aa_nxt    = aa_r;
    pub_nxt   = pub_r;
    done_nxt  = 1'b0;
    if (inq_item.action == ACT_CLEAR) begin
      for (int i = 0; i < METRICS; i++) begin
        sums_nxt[i] = '0;
        max_nxt[i]  = '0;
      end
      count_nxt = '0;
      warm_nxt  = cfg_warmup;
      rej_nxt   = '0;
      aa_nxt    = 1'b0;
      pub_nxt   = 1'b0;
    end else begin
      aa_nxt = inq_item.aa_fault;
      if (cfg_enable && inq_item.eligible) begin
        priority if (inq_item.task_ticks >= cfg_threshold) begin
          rej_nxt = rej_r + 32'd1;
        end else if (warm_r != '0) begin
          warm_nxt = warm_r - 8'd1;
        end else if (count_inc >= WIN_C) begin
          // window complete: snapshot goes to the job, state restarts
          for (int i = 0; i < METRICS; i++) begin
            sums_nxt[i] = '0;
            max_nxt[i]  = '0;
          end
          count_nxt = '0;
          pub_nxt   = 1'b1;
          done_nxt  = 1'b1;
        end else begin
          sums_nxt  = acc_sum;
          max_nxt   = acc_max;
          count_nxt = count_inc;
        end
      end
    end
  end

  assign iss_last    = !job_done_r || (iss_idx_r == LAST_IDX);
  assign issue_valid = job_valid_r && adv;
  assign job_free    = issue_valid && iss_last;
  assign take        = inq_valid && (!job_valid_r || job_free);

  always_comb begin
    issue.done = job_done_r;
    issue.idx  = METRIC_IDX_W'(iss_idx_r);
    issue.last = iss_last;
    issue.stat = job_stat_r;
    issue.sum  = snap_sum_r[0];
    issue.mx   = snap_max_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < METRICS; i++) begin
        sums_r[i] <= '0;
        max_r[i]  <= '0;
      end
      count_r     <= '0;
      warm_r      <= WARMUP_RESET;
      rej_r       <= '0;
      aa_r        <= 1'b0;
      pub_r       <= 1'b0;
      job_valid_r <= 1'b0;
      iss_idx_r   <= '0;
    end else begin
      if (take) begin
        sums_r      <= sums_nxt;
        max_r       <= max_nxt;
        count_r     <= count_nxt;
        warm_r      <= warm_nxt;
        rej_r       <= rej_nxt;
        aa_r        <= aa_nxt;
        pub_r       <= pub_nxt;
        job_valid_r <= 1'b1;
        iss_idx_r   <= '0;
      end else if (job_free) begin
        job_valid_r <= 1'b0;
        iss_idx_r   <= '0;
      end else if (issue_valid) begin
        iss_idx_r <= iss_idx_r + 1'b1;
      end
    end
  end

  // job payload, shifted down one metric per issued result
  always_ff @(posedge clk) begin
    if (take) begin
      job_done_r             <= done_nxt;
      job_stat_r.have_window <= pub_nxt;
      job_stat_r.collected   <= count_nxt;
      job_stat_r.warmup_left <= warm_nxt;
      job_stat_r.rejected    <= rej_nxt;
      job_stat_r.aa_error    <= aa_nxt;
      snap_sum_r             <= acc_sum;
      snap_max_r             <= acc_max;
    end else if (issue_valid) begin
      for (int i = 0; i < METRICS - 1; i++) begin
        snap_sum_r[i] <= snap_sum_r[i+1];
        snap_max_r[i] <= snap_max_r[i+1];
      end
    end
  end

  `WMS_ASSERT_NOW(a_count_below_window, clk, rst_n, 1'b1, count_r < WIN_C,
    "window count reached window length")
  `WMS_ASSERT_NOW(a_single_result_idx, clk, rst_n, job_valid_r && !job_done_r,
    iss_idx_r == '0, "plain item issued more than one result")
  `WMS_ASSERT_NEXT(a_job_released, clk, rst_n, job_free && !take,
    !job_valid_r, "job held after its last result")

endmodule

@@ src/wms_div.sv @@
// window average by reciprocal multiply, and the result register
module wms_div #(
  parameter int WINDOW = 60
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  issue_valid,
  input  wms_pkg::issue_t       issue,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_window_done,
  output logic [2:0]            out_metric_index,
  output logic [31:0]           out_average,
  output logic [31:0]           out_maximum,
  output logic                  out_have_window,
  output logic [7:0]            out_collected,
  output logic [7:0]            out_warmup_left,
  output logic [31:0]           out_rejected,
  output logic                  out_aa_error,
  output logic                  out_last
);
  import wms_pkg::*;

  // floor(x * RECIP / 2^(32+K)) is the quotient or one below it
  localparam int K = $clog2(WINDOW + 1) - 1;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << (32 + K)) - 64'd1) / 64'(WINDOW);
  localparam logic [DATA_W-1:0] RECIP = RECIP_FULL[DATA_W-1:0];
  localparam logic [DATA_W-1:0] WIN_D = DATA_W'(WINDOW);

  logic              s1_valid_r;
  issue_t            s1_r;
  logic [63:0]       s1_prod_r;
  logic              out_valid_r;
  issue_t            out_r;
  logic [DATA_W-1:0] avg_r;

  logic [DATA_W-1:0] q_est;
  logic [DATA_W-1:0] q_mul;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;

  assign adv = !out_valid_r || out_ready;

  always_comb begin
    q_est = DATA_W'(s1_prod_r >> (32 + K));
    q_mul = q_est * WIN_D;
    rem   = s1_r.sum - q_mul;
    quot  = (rem >= WIN_D) ? q_est + 32'd1 : q_est;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= issue_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= issue;
      s1_prod_r <= {32'd0, issue.sum} * {32'd0, RECIP};
      out_r     <= s1_r;
      avg_r     <= quot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_done  = out_r.done;
  assign out_metric_index = out_r.done ? out_r.idx : '0;
  assign out_average      = out_r.done ? avg_r : '0;
  assign out_maximum      = out_r.done ? out_r.mx : '0;
  assign out_have_window  = out_r.stat.have_window;
  assign out_collected    = out_r.stat.collected;
  assign out_warmup_left  = out_r.stat.warmup_left;
  assign out_rejected     = out_r.stat.rejected;
  assign out_aa_error     = out_r.stat.aa_error;
  assign out_last         = out_r.last;

endmodule

@@ src/windowed_metric_stats.sv @@
// windowed performance-counter statistics, top level
// path: an accepted item passes the input, job, divider product and result registers
// throughput: one item per cycle while out_ready keeps the result path moving; an
// item that closes a window holds the path while it issues one result per metric
// reset: synchronous active low, clears all statistics and loads register defaults
module windowed_metric_stats #(
  parameter int WINDOW  = 60,
  parameter int METRICS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic        in_eligible,
  input  logic        in_aa_fault,
  input  logic [31:0] in_task_ticks,
  input  logic [23:0] in_cmd_busy,
  input  logic [23:0] in_pipe_busy,
  input  logic [23:0] in_tmem_busy,
  input  logic [31:0] in_aux_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_window_done,
  output logic [2:0]  out_metric_index,
  output logic [31:0] out_average,
  output logic [31:0] out_maximum,
  output logic        out_have_window,
  output logic [7:0]  out_collected,
  output logic [7:0]  out_warmup_left,
  output logic [31:0] out_rejected,
  output logic        out_aa_error,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import wms_pkg::*;

  logic               enable_r;
  logic [DATA_W-1:0]  thr_r;
  logic [COUNT_W-1:0] warmup_r;

  logic               inq_valid_r;
  in_item_t           inq_r;
  logic               take;
  logic               adv;
  logic               issue_valid;
  issue_t             issue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ENABLE_RESET;
      thr_r    <= THRESHOLD_RESET;
      warmup_r <= WARMUP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable_r <= cfg_data[0];
        CFG_THRESHOLD: thr_r    <= cfg_data;
        CFG_WARMUP:    warmup_r <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // input register
  assign in_ready = !inq_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid_r <= 1'b1;
    end else if (take) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r.action     <= in_action;
      inq_r.eligible   <= in_eligible;
      inq_r.aa_fault   <= in_aa_fault;
      inq_r.task_ticks <= in_task_ticks;
      inq_r.cmd_busy   <= in_cmd_busy;
      inq_r.pipe_busy  <= in_pipe_busy;
      inq_r.tmem_busy  <= in_tmem_busy;
      inq_r.aux_ticks  <= in_aux_ticks;
    end
  end

  wms_stats #(
    .WINDOW  (WINDOW),
    .METRICS (METRICS)
  ) u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .inq_valid     (inq_valid_r),
    .inq_item      (inq_r),
    .cfg_enable    (enable_r),
    .cfg_threshold (thr_r),
    .cfg_warmup    (warmup_r),
    .adv           (adv),
    .take          (take),
    .issue_valid   (issue_valid),
    .issue         (issue)
  );

  wms_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .issue_valid      (issue_valid),
    .issue            (issue),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_done  (out_window_done),
    .out_metric_index (out_metric_index),
    .out_average      (out_average),
    .out_maximum      (out_maximum),
    .out_have_window  (out_have_window),
    .out_collected    (out_collected),
    .out_warmup_left  (out_warmup_left),
    .out_rejected     (out_rejected),
    .out_aa_error     (out_aa_error),
    .out_last         (out_last)
  );

endmodule
